// ===== src/multi_waveform_phase_oscillator_top_assert.svh =====
// Assertion macros for the oscillator.
`ifndef MULTI_WAVEFORM_PHASE_OSCILLATOR_TOP_ASSERT_SVH
`define MULTI_WAVEFORM_PHASE_OSCILLATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define MWPO_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mwpo assertion failed");
`define MWPO_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("mwpo reset assertion failed");
`else
`define MWPO_ASSERT(lbl, clk, rst_n, prop)
`define MWPO_ASSERT_RST(lbl, clk, prop)
`endif

`endif

// ===== src/mwpo_pkg.sv =====
package mwpo_pkg;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SAW    = 2'd1,
    WAVE_SQUARE = 2'd2,
    WAVE_TRI    = 2'd3
  } wave_t;

  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_SELECT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_OFFSET = 2'd2;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1 <<< 30;

  // term * x^2 in Q30, truncated after each product
  function automatic longint mul_x2_q30(input longint term, input longint x);
    longint t;
    t = (term * x) >>> 30;
    t = (t * x) >>> 30;
    return t;
  endfunction

  // Quarter-wave sine entry k, elaboration-time only.
  function automatic int sine_entry(input int k, input int tbl_bits, input int smp_bits);
    longint x;
    longint term;
    longint sum;
    longint full;
    longint v;
    full = (64'sd1 <<< (smp_bits - 1)) - 64'sd1;
    if (k == (1 << tbl_bits)) begin
      return int'(full);
    end
    x = (HALF_PI_Q30 * longint'(k)) >>> tbl_bits;
    term = x;
    sum = x;
    term = mul_x2_q30(term, x) / 64'sd6;   sum = sum - term;
    term = mul_x2_q30(term, x) / 64'sd20;  sum = sum + term;
    term = mul_x2_q30(term, x) / 64'sd42;  sum = sum - term;
    term = mul_x2_q30(term, x) / 64'sd72;  sum = sum + term;
    term = mul_x2_q30(term, x) / 64'sd110; sum = sum - term;
    term = mul_x2_q30(term, x) / 64'sd156; sum = sum + term;
    term = mul_x2_q30(term, x) / 64'sd210; sum = sum - term;
    term = mul_x2_q30(term, x) / 64'sd272; sum = sum + term;
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    v = (sum * full + (ONE_Q30 >>> 1)) >>> 30;
    if (v > full) v = full;
    return int'(v);
  endfunction

endpackage

// ===== src/mwpo_if.sv =====
interface mwpo_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface mwpo_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          wrapped;

  modport source (output valid, output sample, output wrapped, input ready);
  modport sink   (input valid, input sample, input wrapped, output ready);
endinterface

// ===== src/mwpo_wave.sv =====
module mwpo_wave #(
  parameter int PHASE_BITS      = 16,
  parameter int SAMPLE_BITS     = 16,
  parameter int SINE_TABLE_BITS = 8
) (
  input  mwpo_pkg::wave_t               wave_sel,
  input  logic [PHASE_BITS-1:0]         phase,
  output logic signed [SAMPLE_BITS-1:0] sample
);

  localparam int TBL_Q = 1 << SINE_TABLE_BITS;
  localparam int QBITS = PHASE_BITS - 2;
  localparam int D_SINE = QBITS - SINE_TABLE_BITS;
  localparam int D_SCALE = PHASE_BITS + 1 - SAMPLE_BITS;
  localparam logic signed [SAMPLE_BITS-1:0] FULL =
    {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] NEG_HALF =
    {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [SAMPLE_BITS-2:0] rom [TBL_Q+1];

  for (genvar k = 0; k <= TBL_Q; k++) begin : g_rom
    localparam int V = mwpo_pkg::sine_entry(k, SINE_TABLE_BITS, SAMPLE_BITS);
    assign rom[k] = V[SAMPLE_BITS-2:0];
  end

  // sine
  logic [1:0]                   quad;
  logic [SINE_TABLE_BITS-1:0]   idx;
  logic [SINE_TABLE_BITS:0]     rom_addr;
  logic [SAMPLE_BITS-2:0]       mag;
  logic signed [SAMPLE_BITS-1:0] sine_val;

  assign quad = phase[PHASE_BITS-1 -: 2];

  if (D_SINE >= 0) begin : g_idx_trunc
    assign idx = phase[QBITS-1 -: SINE_TABLE_BITS];
  end else begin : g_idx_fill
    assign idx = {phase[QBITS-1:0], {(-D_SINE){1'b0}}};
  end

  assign rom_addr = quad[0] ? ((SINE_TABLE_BITS+1)'(TBL_Q) - {1'b0, idx}) : {1'b0, idx};
  assign mag = rom[rom_addr];
  assign sine_val = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  // sawtooth / triangle share one scaler; b spans [0, 2C]
  logic [PHASE_BITS-1:0] saw_s;
  logic [PHASE_BITS-1:0] tri_t;
  logic [PHASE_BITS-1:0] tri_neg;
  logic [PHASE_BITS+1:0] b;
  logic [SAMPLE_BITS:0]  sh;
  logic signed [SAMPLE_BITS-1:0] scaled;

  assign saw_s = {~phase[PHASE_BITS-1], phase[PHASE_BITS-2:0]};
  assign tri_t = phase + {2'b01, {(PHASE_BITS-2){1'b0}}};
  assign tri_neg = ~tri_t + 1'b1;

  always_comb begin
    if (wave_sel == mwpo_pkg::WAVE_SAW) begin
      b = {1'b0, saw_s, 1'b0};
    end else if (!tri_t[PHASE_BITS-1]) begin
      b = {tri_t, 2'b00};
    end else begin
      b = {tri_neg, 2'b00};
    end
  end

  if (D_SCALE >= 0) begin : g_sh_right
    assign sh = b[PHASE_BITS+1:D_SCALE];
  end else begin : g_sh_left
    assign sh = {b, {(-D_SCALE){1'b0}}};
  end

  assign scaled = sh[SAMPLE_BITS] ? FULL : $signed({~sh[SAMPLE_BITS-1], sh[SAMPLE_BITS-2:0]});

  always_comb begin
    unique case (wave_sel)
      mwpo_pkg::WAVE_SINE:   sample = sine_val;
      mwpo_pkg::WAVE_SQUARE: sample = phase[PHASE_BITS-1] ? NEG_HALF : FULL;
      mwpo_pkg::WAVE_SAW,
      mwpo_pkg::WAVE_TRI:    sample = scaled;
      default:               sample = sine_val;
    endcase
  end

endmodule

// ===== src/multi_waveform_phase_oscillator_top.sv =====
// A request accepted at a clock edge has its result registered and valid right after that edge.
// Throughput: one request per cycle while results are taken; phase add, table lookup and scaling sit in one stage.
// A pending result that is not taken holds the input off only until it is taken.
// Reset (synchronous, rst_n low): phase cleared, registers to defaults
// (sine, step 256, offset 0), output empty.
`include "multi_waveform_phase_oscillator_top_assert.svh"

module multi_waveform_phase_oscillator_top #(
  parameter int PHASE_BITS      = 16,
  parameter int SAMPLE_BITS     = 16,
  parameter int SINE_TABLE_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  mwpo_in_if.sink                             in_if,
  mwpo_out_if.source                          out_if,
  input  logic                                cfg_we,
  input  logic [mwpo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [PHASE_BITS-1:0]               cfg_wdata
);

  localparam logic [PHASE_BITS-1:0] STEP_RESET = PHASE_BITS'(256);

  mwpo_pkg::wave_t       wave_r;
  logic [PHASE_BITS-1:0] phase_step_r;
  logic [PHASE_BITS-1:0] phase_offset_r;
  logic [PHASE_BITS-1:0] phase_accum_r;
  logic                  out_valid_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                  wrapped_r;

  logic                  in_accept;
  logic [PHASE_BITS-1:0] phase_base;
  logic [PHASE_BITS-1:0] eval_phase;
  logic [PHASE_BITS:0]   phase_sum;
  logic [PHASE_BITS-1:0] phase_accum_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_nxt;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_accept = in_if.valid && in_if.ready;

  assign phase_base = in_if.restart ? '0 : phase_accum_r;
  assign eval_phase = phase_base + phase_offset_r;
  assign phase_sum = {1'b0, phase_base} + {1'b0, phase_step_r};
  assign phase_accum_nxt = phase_sum[PHASE_BITS-1:0];

  mwpo_wave #(
    .PHASE_BITS      (PHASE_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_wave (
    .wave_sel (wave_r),
    .phase    (eval_phase),
    .sample   (sample_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r         <= mwpo_pkg::WAVE_SINE;
      phase_step_r   <= STEP_RESET;
      phase_offset_r <= '0;
      phase_accum_r  <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mwpo_pkg::REG_WAVE_SELECT:  wave_r <= mwpo_pkg::wave_t'(cfg_wdata[1:0]);
          mwpo_pkg::REG_PHASE_STEP:   phase_step_r <= cfg_wdata;
          mwpo_pkg::REG_PHASE_OFFSET: phase_offset_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_accept) begin
        phase_accum_r <= phase_accum_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_r  <= sample_nxt;
      wrapped_r <= phase_sum[PHASE_BITS];
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.sample  = sample_r;
  assign out_if.wrapped = wrapped_r;

  `MWPO_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_valid_r)
  `MWPO_ASSERT(a_accept_gives_result, clk, rst_n, in_accept |=> out_valid_r)
  `MWPO_ASSERT(a_phase_hold, clk, rst_n, !in_accept |=> $stable(phase_accum_r))
  `MWPO_ASSERT(a_phase_advance, clk, rst_n, (in_accept && !in_if.restart) |=> (phase_accum_r == $past(phase_accum_nxt)))
  `MWPO_ASSERT(a_restart_step, clk, rst_n, (in_accept && in_if.restart) |=> (phase_accum_r == $past(phase_step_r)))

endmodule

// ===== tb/mwpo_sample_check.sv =====
`timescale 1ns / 1ps

module mwpo_sample_check (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_restart,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [15:0]                  out_sample,
  input  logic                                out_wrapped,
  input  logic                                cfg_we,
  input  logic [mwpo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [15:0]                         cfg_wdata,
  output int                                  errors,
  output int                                  pending
);

  typedef struct packed {
    logic signed [15:0] sample;
    logic               wrapped;
  } osc_result_t;

  int              quarter_tbl [0:256];
  osc_result_t     expected_samples [$];
  mwpo_pkg::wave_t wave;
  logic [15:0]     step;
  logic [15:0]     offset;
  logic [15:0]     accum;
  int              err_cnt;

  initial begin : build_quarter_tbl
    longint x;
    longint term;
    longint sum;
    longint v;
    for (int k = 0; k <= 256; k++) begin
      x = (64'sd1686629713 * longint'(k)) / 64'sd256;
      term = x;
      sum = x;
      for (int n = 1; n <= 8; n++) begin
        term = (term * x) >>> 30;
        term = (term * x) >>> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      if (sum < 0) sum = 0;
      if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
      v = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
      if (v > 32767) v = 32767;
      quarter_tbl[k] = int'(v);
    end
    quarter_tbl[256] = 32767;
  end

  // waveform value at evaluation phase p
  function automatic logic signed [15:0] wave_value(input logic [15:0] p);
    logic [15:0] s;
    int          idx;
    int          t;
    int          b;
    int          v;
    case (wave)
      mwpo_pkg::WAVE_SINE: begin
        idx = int'(p[13:6]);
        v = p[14] ? quarter_tbl[256 - idx] : quarter_tbl[idx];
        if (p[15]) v = -v;
      end
      mwpo_pkg::WAVE_SAW: begin
        s = p + 16'h8000;
        v = int'(s) - 32768;
      end
      mwpo_pkg::WAVE_SQUARE: begin
        v = p[15] ? -32768 : 32767;
      end
      default: begin
        s = p + 16'h4000;
        t = int'(s);
        b = (t < 32768) ? 4 * t : 4 * (65536 - t);
        v = b / 2 - 32768;
        if (v > 32767) v = 32767;
      end
    endcase
    return 16'(v);
  endfunction

  always @(posedge clk) begin
    osc_result_t want;
    logic [15:0] p;
    logic [16:0] nxt;
    if (!rst_n) begin
      wave = mwpo_pkg::WAVE_SINE;
      step = 16'd256;
      offset = 16'd0;
      accum = 16'd0;
      err_cnt = 0;
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mwpo_pkg::REG_WAVE_SELECT:  wave = mwpo_pkg::wave_t'(cfg_wdata[1:0]);
          mwpo_pkg::REG_PHASE_STEP:   step = cfg_wdata;
          mwpo_pkg::REG_PHASE_OFFSET: offset = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected result: sample %0d wrapped %0b", out_sample, out_wrapped);
          err_cnt++;
        end else begin
          want = expected_samples.pop_front();
          if (out_sample !== want.sample) begin
            $error("sample mismatch: expected %0d, actual %0d", want.sample, out_sample);
            err_cnt++;
          end
          if (out_wrapped !== want.wrapped) begin
            $error("wrapped mismatch: expected %0b, actual %0b", want.wrapped, out_wrapped);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_restart) accum = 16'd0;
        p = accum + offset;
        want.sample = wave_value(p);
        nxt = {1'b0, accum} + {1'b0, step};
        want.wrapped = nxt[16];
        accum = nxt[15:0];
        expected_samples.push_back(want);
      end
    end
    errors <= err_cnt;
    pending <= expected_samples.size();
  end

endmodule

// ===== tb/tb_multi_waveform_phase_oscillator_top.sv =====
`timescale 1ns / 1ps

module tb_multi_waveform_phase_oscillator_top;

  localparam logic [mwpo_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 750;
  localparam int HOLD_CYCLES = 80;

  logic                                clk;
  logic                                rst_n;
  logic                                cfg_we;
  logic [mwpo_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [15:0]                         cfg_wdata;
  int                                  errors;
  int                                  pending;

  bit no_idle;
  int sent;
  int hold_req;
  int holds_done;

  mwpo_in_if                        in_ch ();
  mwpo_out_if #(.SAMPLE_BITS(16))   out_ch ();

  multi_waveform_phase_oscillator_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  mwpo_sample_check u_sample_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_restart (in_ch.restart),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_sample (out_ch.sample),
    .out_wrapped(out_ch.wrapped),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  // result side
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 13);
      if (holds_done != hold_req) begin
        holds_done = hold_req;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_tick(input logic restart);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_osc(input logic [15:0] wave_word, input logic [15:0] step,
                             input logic [15:0] offset);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= mwpo_pkg::REG_WAVE_SELECT;
    cfg_wdata <= wave_word;
    @(posedge clk);
    cfg_index <= mwpo_pkg::REG_PHASE_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_index <= mwpo_pkg::REG_PHASE_OFFSET;
    cfg_wdata <= offset;
    @(posedge clk);
    // beyond the register list: ignored
    cfg_index <= REG_UNUSED;
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd1;
      3:       return 16'h8000;
      4:       return 16'($urandom_range(1, 1024));
      5:       return 16'(65536 / $urandom_range(3, 1000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_offset();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int phase_no;
    int n_items;
    logic [15:0] wave_word;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.restart <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= mwpo_pkg::REG_WAVE_SELECT;
    cfg_wdata <= 16'd0;
    no_idle = 1'b0;
    sent = 0;
    hold_req = 0;
    holds_done = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // defaults after reset
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);

    // sine quadrants and a wrap
    program_osc({14'd0, mwpo_pkg::WAVE_SINE}, 16'h4000, 16'h0000);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);

    program_osc({14'd0, mwpo_pkg::WAVE_SAW}, 16'hFFFF, 16'hFFFF);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);

    program_osc({14'd0, mwpo_pkg::WAVE_SQUARE}, 16'h8000, 16'h7FFF);
    send_tick(1'b1);
    repeat (2) send_tick(1'b0);

    // triangle peak saturates to full scale
    program_osc({14'd0, mwpo_pkg::WAVE_TRI}, 16'h4000, 16'h0000);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);

    // upper bits of the wave word are masked off
    program_osc(16'hFFFC, 16'h0000, 16'hFFFF);
    send_tick(1'b0);
    send_tick(1'b1);

    phase_no = 0;
    while (sent < ITEM_TARGET) begin
      wave_word = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      program_osc(wave_word, pick_step(), pick_offset());
      no_idle = ($urandom_range(0, 4) == 0);
      if (phase_no == 2) hold_req++;
      n_items = $urandom_range(30, 70);
      for (int i = 0; i < n_items; i++) begin
        if (phase_no == 4 && i == n_items / 2) drain();
        send_tick($urandom_range(0, 15) == 0);
      end
      phase_no++;
    end

    no_idle = 1'b0;
    drain();
    repeat (5) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== multi_waveform_phase_oscillator_top.f =====
+incdir+src
src/mwpo_pkg.sv
src/mwpo_if.sv
src/mwpo_wave.sv
src/multi_waveform_phase_oscillator_top.sv
tb/mwpo_sample_check.sv
tb/tb_multi_waveform_phase_oscillator_top.sv
